/* hdl/decimal_text_to_int64_saturating_assert.svh */
// Assertion helpers for the top-level RTL file of the decimal parser.
`ifndef DECIMAL_TEXT_TO_INT64_SATURATING_ASSERT_SVH
`define DECIMAL_TEXT_TO_INT64_SATURATING_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTOI_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("assertion failed in decimal parser");

// The consequent must hold in the cycle after the antecedent.
`define DTOI_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("assertion failed in decimal parser");

`endif

/* hdl/dtoi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dtoi_pkg;

  localparam int CODE_W = 21;
  localparam int VAL_W  = 64;

  localparam logic [CODE_W-1:0] CH_TAB   = 21'd9;
  localparam logic [CODE_W-1:0] CH_CR    = 21'd13;
  localparam logic [CODE_W-1:0] CH_SPACE = 21'd32;
  localparam logic [CODE_W-1:0] CH_PLUS  = 21'd43;
  localparam logic [CODE_W-1:0] CH_MINUS = 21'd45;
  localparam logic [CODE_W-1:0] CH_ZERO  = 21'd48;
  localparam logic [CODE_W-1:0] CH_NINE  = 21'd57;

  localparam logic [VAL_W-1:0] SMAX      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VAL_W-1:0] SMIN_BITS = 64'h8000_0000_0000_0000;
  // Largest magnitude that can still take another digit: floor(SMAX / 10).
  localparam logic [VAL_W-1:0] CUT_DIV   = 64'd922337203685477580;

  localparam logic [3:0] LIM_NEG = 4'd8;
  localparam logic [3:0] LIM_POS = 4'd7;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [CODE_W-1:0] char_code;
    logic              last_char;
    logic              empty_string;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    overflowed;
    logic                    sign_error;
  } out_item_t;

  typedef struct packed {
    phase_t           phase;
    logic             is_negative;
    logic             overflow_seen;
    logic [VAL_W-1:0] magnitude;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:         PH_SKIP,
    is_negative:   1'b0,
    overflow_seen: 1'b0,
    magnitude:     '0
  };

endpackage

`default_nettype wire

/* hdl/dtoi_step.sv */
`timescale 1ns / 1ps
`default_nettype none

// Next parse state and the result for one character.
module dtoi_step (
  input  wire dtoi_pkg::in_item_t     item,
  input  wire dtoi_pkg::parse_state_t st,
  input  wire                         unsigned_mode,
  output dtoi_pkg::parse_state_t      st_nxt,
  output logic                        res_valid,
  output dtoi_pkg::out_item_t         res
);

  logic                    is_digit;
  logic                    is_space;
  logic                    is_sign;
  logic [3:0]              digit;
  logic [3:0]              lim;
  logic [dtoi_pkg::VAL_W-1:0] mag_x10;
  logic                    sign_last;
  dtoi_pkg::parse_state_t  acc;

  assign is_digit = (item.char_code inside {[dtoi_pkg::CH_ZERO:dtoi_pkg::CH_NINE]});
  assign is_space = (item.char_code == dtoi_pkg::CH_SPACE) ||
                    (item.char_code inside {[dtoi_pkg::CH_TAB:dtoi_pkg::CH_CR]});
  assign is_sign  = (item.char_code == dtoi_pkg::CH_MINUS) ||
                    (item.char_code == dtoi_pkg::CH_PLUS);
  assign digit    = 4'(item.char_code - dtoi_pkg::CH_ZERO);
  assign mag_x10  = (st.magnitude << 3) + (st.magnitude << 1);

  // Digit accumulation; the cutoff allows one more unit for a signed negative.
  function automatic dtoi_pkg::parse_state_t take_digit(
    input dtoi_pkg::parse_state_t s,
    input logic                   dig_ok,
    input logic [3:0]             d,
    input logic [3:0]             l,
    input logic [dtoi_pkg::VAL_W-1:0] m10
  );
    dtoi_pkg::parse_state_t r;
    r = s;
    r.phase = dtoi_pkg::PH_DIGITS;
    if (!dig_ok) begin
      r.phase = dtoi_pkg::PH_DONE;
    end else if (s.overflow_seen || (s.magnitude > dtoi_pkg::CUT_DIV) ||
                 ((s.magnitude == dtoi_pkg::CUT_DIV) && (d > l))) begin
      r.overflow_seen = 1'b1;
    end else begin
      r.magnitude = m10 + {{(dtoi_pkg::VAL_W-4){1'b0}}, d};
    end
    return r;
  endfunction

  always_comb begin
    lim = (st.is_negative && !unsigned_mode) ? dtoi_pkg::LIM_NEG : dtoi_pkg::LIM_POS;
    acc       = st;
    sign_last = 1'b0;
    case (st.phase)
      dtoi_pkg::PH_SKIP: begin
        if (is_space) begin
          acc = st;
        end else if (is_sign) begin
          acc.is_negative = (item.char_code == dtoi_pkg::CH_MINUS);
          acc.phase       = dtoi_pkg::PH_DIGITS;
          sign_last       = 1'b1;
        end else begin
          acc = take_digit(st, is_digit, digit, lim, mag_x10);
        end
      end
      dtoi_pkg::PH_DIGITS: begin
        acc = take_digit(st, is_digit, digit, lim, mag_x10);
      end
      default: begin
        acc.phase = dtoi_pkg::PH_DONE;
      end
    endcase
  end

  always_comb begin
    st_nxt    = acc;
    res_valid = 1'b0;
    res       = '0;
    if (item.empty_string) begin
      st_nxt    = dtoi_pkg::STATE_RESET;
      res_valid = 1'b1;
    end else if (item.last_char) begin
      st_nxt    = dtoi_pkg::STATE_RESET;
      res_valid = 1'b1;
      if (sign_last) begin
        res = '0;
      end else if (unsigned_mode && acc.is_negative) begin
        res.sign_error = 1'b1;
      end else if (acc.overflow_seen) begin
        res.value      = acc.is_negative ? dtoi_pkg::SMIN_BITS : dtoi_pkg::SMAX;
        res.overflowed = 1'b1;
      end else begin
        res.value = acc.is_negative ? (64'd0 - acc.magnitude) : acc.magnitude;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/decimal_text_to_int64_saturating.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Payload            Handshake
// in       input      dtoi_pkg::in_item_t  in_valid / in_ready
// out      output     dtoi_pkg::out_item_t out_valid / out_ready
// cfg      input      unsigned_mode bit  cfg_valid / cfg_ready (always ready)
//
// One character per cycle unless a result stalls: a transaction sits in the
// input register while the parse step computes the next state and the
// result register. The recurrence is the multiply-by-ten, add and cutoff
// compare. A result turns valid as its last character leaves the input register.
// Synchronous reset clears the parse state, the mode bit and both valid flags.
// A stalled result holds the parse stage only when the next character ends
// a string or is an empty string; other characters keep flowing.
module decimal_text_to_int64_saturating (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire dtoi_pkg::in_item_t in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output dtoi_pkg::out_item_t  out_data,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire                  cfg_data
);

  `include "decimal_text_to_int64_saturating_assert.svh"

  dtoi_pkg::in_item_t     in_r;
  logic                   in_valid_r;
  dtoi_pkg::parse_state_t st_r;
  dtoi_pkg::parse_state_t st_nxt;
  dtoi_pkg::out_item_t    out_r;
  dtoi_pkg::out_item_t    res;
  logic                   out_valid_r;
  logic                   mode_r;
  logic                   res_valid;
  logic                   advance;

  dtoi_step u_step (
    .item          (in_r),
    .st            (st_r),
    .unsigned_mode (mode_r),
    .st_nxt        (st_nxt),
    .res_valid     (res_valid),
    .res           (res)
  );

  assign advance   = in_valid_r && (!res_valid || !out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid) begin
      mode_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= dtoi_pkg::STATE_RESET;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_r <= res;
    end
  end

  `DTOI_ASSERT_IMP(a_sign_err_zero, clk, rst_n, out_valid_r && out_r.sign_error,
                   (out_r.value == 64'd0) && !out_r.overflowed)
  `DTOI_ASSERT_IMP(a_ovf_saturated, clk, rst_n, out_valid_r && out_r.overflowed,
                   (out_r.value == dtoi_pkg::SMAX) || (out_r.value == dtoi_pkg::SMIN_BITS))
  `DTOI_ASSERT_NXT(a_clear_after_result, clk, rst_n, advance && res_valid,
                   (st_r.phase == dtoi_pkg::PH_SKIP) && (st_r.magnitude == 64'd0) &&
                   !st_r.overflow_seen && !st_r.is_negative)
  `DTOI_ASSERT_IMP(a_mag_bound, clk, rst_n, st_r.phase != dtoi_pkg::PH_SKIP,
                   st_r.magnitude <= dtoi_pkg::SMIN_BITS)
  `DTOI_ASSERT_IMP(a_ovf_phase, clk, rst_n, st_r.overflow_seen,
                   st_r.phase != dtoi_pkg::PH_SKIP)

endmodule

`default_nettype wire

/* sim/tb_decimal_text_to_int64_saturating.sv */
`timescale 1ns / 1ps

module tb_decimal_text_to_int64_saturating;
  import dtoi_pkg::*;

  localparam logic [63:0] POS_LIMIT  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAG_CUTOFF = 64'd922337203685477580;
  localparam logic [20:0] CH_LOW_X   = 21'd120;
  localparam logic [20:0] CODE_TOP   = 21'h1F_FFFF;
  localparam int          SETTLE     = 8;
  localparam int          PHASE_LEN  = 210;
  localparam int          NUM_ROWS   = 24;

  typedef struct packed {
    logic                    mode;
    logic [20:0]             code;
    logic                    last;
    logic                    empty;
    logic                    typed;
    logic signed [63:0]      val;
    logic                    ov;
    logic                    se;
  } dir_row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;

  // Predictor state for the string being parsed.
  phase_t      cur_phase    = PH_SKIP;
  logic        neg_sign     = 1'b0;
  logic        ovf_flag     = 1'b0;
  logic [63:0] acc_mag      = '0;
  logic        unsigned_sel = 1'b0;

  out_item_t want_q[$];
  int snd_idle = 14;
  int rcv_idle = 73;
  int n_items  = 0;
  int n_res    = 0;
  int n_ovf    = 0;
  int n_serr   = 0;
  int n_err    = 0;

  dir_row_t dir_rows [NUM_ROWS];

  decimal_text_to_int64_saturating i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("decimal_text_to_int64_saturating test failed");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  // Result checker: every result transaction is matched to the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (want_q.size() == 0) begin
        $display("%0t: unexpected result, got value %0d ovf %0b serr %0b", $time,
                 out_data.value, out_data.overflowed, out_data.sign_error);
        n_err++;
      end else begin
        exp_r = want_q.pop_front();
        n_res++;
        if (out_data.overflowed) n_ovf++;
        if (out_data.sign_error) n_serr++;
        if (out_data.value !== exp_r.value) begin
          $display("%0t: value mismatch, expected %0d, got %0d", $time,
                   exp_r.value, out_data.value);
          n_err++;
        end
        if (out_data.overflowed !== exp_r.overflowed) begin
          $display("%0t: overflowed mismatch, expected %0b, got %0b", $time,
                   exp_r.overflowed, out_data.overflowed);
          n_err++;
        end
        if (out_data.sign_error !== exp_r.sign_error) begin
          $display("%0t: sign_error mismatch, expected %0b, got %0b", $time,
                   exp_r.sign_error, out_data.sign_error);
          n_err++;
        end
      end
    end
  end

  function automatic void clear_parse();
    cur_phase = PH_SKIP;
    neg_sign  = 1'b0;
    ovf_flag  = 1'b0;
    acc_mag   = '0;
  endfunction

  function automatic void take_digit(input logic [20:0] c);
    logic [63:0] d;
    logic [63:0] lim;
    if (c < CH_ZERO || c > CH_NINE) begin
      cur_phase = PH_DONE;
      return;
    end
    d   = 64'(c - CH_ZERO);
    lim = (neg_sign && !unsigned_sel) ? 64'd8 : 64'd7;
    // Once past the cutoff the magnitude freezes and only the flag matters.
    if (ovf_flag || acc_mag > MAG_CUTOFF || (acc_mag == MAG_CUTOFF && d > lim))
      ovf_flag = 1'b1;
    else
      acc_mag = acc_mag * 64'd10 + d;
  endfunction

  // Advances the parse by one character; returns 1 when a result is due.
  function automatic bit parse_char(input in_item_t it, output out_item_t r);
    logic [20:0] c;
    c = it.char_code;
    r = '0;
    if (it.empty_string) begin
      clear_parse();
      return 1'b1;
    end
    case (cur_phase)
      PH_SKIP: begin
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
        end else if (c == CH_MINUS || c == CH_PLUS) begin
          neg_sign  = (c == CH_MINUS);
          cur_phase = PH_DIGITS;
          if (it.last_char) begin
            clear_parse();
            return 1'b1;
          end
        end else begin
          cur_phase = PH_DIGITS;
          take_digit(c);
        end
      end
      PH_DIGITS: take_digit(c);
      default:   cur_phase = PH_DONE;
    endcase
    if (!it.last_char) return 1'b0;
    if (unsigned_sel && neg_sign) begin
      r.sign_error = 1'b1;
    end else if (ovf_flag) begin
      r.value      = neg_sign ? NEG_LIMIT : POS_LIMIT;
      r.overflowed = 1'b1;
    end else begin
      r.value = neg_sign ? -acc_mag : acc_mag;
    end
    clear_parse();
    return 1'b1;
  endfunction

  task automatic put_char(input in_item_t it, output bit got, output out_item_t res);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
    got = parse_char(it, res);
  endtask

  // Waits for the block to go quiet, then writes the mode register.
  task automatic set_mode(input logic m);
    in_valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    unsigned_sel = m;
    cfg_valid <= 1'b0;
  endtask

  function automatic void push_dec(ref int unsigned q[$], input logic [63:0] v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic int unsigned space_code();
    return ($urandom_range(1) == 0) ? CH_SPACE : $urandom_range(CH_TAB, CH_CR);
  endfunction

  function automatic int unsigned noise_code();
    case ($urandom_range(7))
      0:       return $urandom_range(0, CODE_TOP);
      1:       return space_code();
      2:       return ($urandom_range(1) == 0) ? CH_PLUS : CH_MINUS;
      3:       return $urandom_range(CH_ZERO, CH_NINE);
      4:       return $urandom_range(33, 127);
      5: begin
        case ($urandom_range(3))
          0:       return CH_TAB - 1;
          1:       return CH_CR + 1;
          2:       return CH_ZERO - 1;
          default: return CH_NINE + 1;
        endcase
      end
      6:       return $urandom_range(21'h11_0000, CODE_TOP);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // Builds one random string; returns 1 if it is to end in an empty-string item.
  function automatic bit make_text(ref int unsigned q[$]);
    int          r;
    int          k;
    logic [63:0] v;
    q.delete();
    r = $urandom_range(99);
    if (r < 8) return 1'b1;
    if (r < 20) begin
      repeat ($urandom_range(1, 4)) q.push_back(noise_code());
      return 1'b0;
    end
    repeat ($urandom_range(0, 2)) q.push_back(space_code());
    case ($urandom_range(3))
      0:       ;
      1:       q.push_back(CH_PLUS);
      default: q.push_back(CH_MINUS);
    endcase
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 2)) q.push_back(CH_ZERO);
    if (r < 42) begin
      v = POS_LIMIT + 64'($urandom_range(0, 6)) - 64'd3;
      push_dec(q, v);
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 3)) q.push_back($urandom_range(CH_ZERO, CH_NINE));
    end else begin
      v = {$urandom, $urandom};
      push_dec(q, v >> $urandom_range(0, 63));
    end
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) q.push_back(noise_code());
    if ($urandom_range(9) == 0) begin
      k = $urandom_range(1, q.size());
      q = q[0:k-1];
    end
    return ($urandom_range(19) == 0 && q.size() > 1);
  endfunction

  task automatic send_text(ref int unsigned q[$], input bit abort);
    in_item_t  it;
    bit        got;
    out_item_t res;
    for (int i = 0; i < q.size(); i++) begin
      it.char_code    = q[i];
      it.last_char    = (i == q.size() - 1) && !abort;
      it.empty_string = 1'b0;
      put_char(it, got, res);
      if (got) want_q.push_back(res);
    end
    if (abort) begin
      it.char_code    = $urandom_range(0, CODE_TOP);
      it.last_char    = $urandom_range(1);
      it.empty_string = 1'b1;
      put_char(it, got, res);
      if (got) want_q.push_back(res);
    end
  endtask

  initial begin
    in_item_t     it;
    bit           got;
    bit           abort;
    out_item_t    res;
    out_item_t    typed_r;
    int unsigned  txt[$];
    int           start_n;

    dir_rows = '{
      '{1'b0, 21'd0,           1'b0, 1'b1, 1'b1,  64'sd0, 1'b0, 1'b0},
      '{1'b0, CODE_TOP,        1'b1, 1'b0, 1'b1,  64'sd0, 1'b0, 1'b0},
      '{1'b0, 21'd0,           1'b1, 1'b0, 1'b1,  64'sd0, 1'b0, 1'b0},
      '{1'b0, CH_SPACE,        1'b0, 1'b0, 1'b0,  64'sd0, 1'b0, 1'b0},
      '{1'b0, CH_TAB,          1'b0, 1'b0, 1'b0,  64'sd0, 1'b0, 1'b0},
      '{1'b0, CH_CR,           1'b0, 1'b0, 1'b0,  64'sd0, 1'b0, 1'b0},
      '{1'b0, CH_PLUS,         1'b1, 1'b0, 1'b1,  64'sd0, 1'b0, 1'b0},
      '{1'b0, CH_SPACE,        1'b1, 1'b0, 1'b1,  64'sd0, 1'b0, 1'b0},
      '{1'b0, CH_MINUS,        1'b0, 1'b0, 1'b0,  64'sd0, 1'b0, 1'b0},
      '{1'b0, CH_NINE,         1'b1, 1'b0, 1'b1, -64'sd9, 1'b0, 1'b0},
      '{1'b0, CH_ZERO,         1'b0, 1'b0, 1'b0,  64'sd0, 1'b0, 1'b0},
      '{1'b0, CH_NINE,         1'b1, 1'b0, 1'b1,  64'sd9, 1'b0, 1'b0},
      '{1'b0, CH_ZERO + 21'd1, 1'b0, 1'b0, 1'b0,  64'sd0, 1'b0, 1'b0},
      '{1'b0, CH_LOW_X,        1'b0, 1'b0, 1'b0,  64'sd0, 1'b0, 1'b0},
      '{1'b0, CH_ZERO + 21'd5, 1'b1, 1'b0, 1'b0,  64'sd0, 1'b0, 1'b0},
      '{1'b0, CH_ZERO + 21'd4, 1'b0, 1'b0, 1'b0,  64'sd0, 1'b0, 1'b0},
      '{1'b0, CH_NINE,         1'b0, 1'b1, 1'b1,  64'sd0, 1'b0, 1'b0},
      '{1'b0, CH_MINUS,        1'b0, 1'b0, 1'b0,  64'sd0, 1'b0, 1'b0},
      '{1'b0, CH_MINUS,        1'b1, 1'b0, 1'b1,  64'sd0, 1'b0, 1'b0},
      '{1'b1, CH_MINUS,        1'b0, 1'b0, 1'b0,  64'sd0, 1'b0, 1'b0},
      '{1'b1, CH_ZERO + 21'd5, 1'b1, 1'b0, 1'b1,  64'sd0, 1'b0, 1'b1},
      '{1'b1, CH_MINUS,        1'b1, 1'b0, 1'b1,  64'sd0, 1'b0, 1'b0},
      '{1'b1, CH_PLUS,         1'b0, 1'b0, 1'b0,  64'sd0, 1'b0, 1'b0},
      '{1'b1, CH_ZERO + 21'd7, 1'b1, 1'b0, 1'b0,  64'sd0, 1'b0, 1'b0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_mode(1'b0);

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (dir_rows[i].mode != unsigned_sel) set_mode(dir_rows[i].mode);
      it.char_code    = dir_rows[i].code;
      it.last_char    = dir_rows[i].last;
      it.empty_string = dir_rows[i].empty;
      put_char(it, got, res);
      if (got) begin
        if (dir_rows[i].typed) begin
          typed_r.value      = dir_rows[i].val;
          typed_r.overflowed = dir_rows[i].ov;
          typed_r.sign_error = dir_rows[i].se;
          want_q.push_back(typed_r);
        end else begin
          want_q.push_back(res);
        end
      end
    end

    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin
          snd_idle = 14;
          rcv_idle = 73;
        end
        1: begin
          snd_idle = 73;
          rcv_idle = 14;
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
        end
      endcase
      set_mode(p == 1 || p == 2 || p == 5);
      start_n = n_items;
      while (n_items - start_n < PHASE_LEN) begin
        abort = make_text(txt);
        send_text(txt, abort);
        // Now and then hold the input off until every pending result is out.
        if ($urandom_range(59) == 0) begin
          in_valid <= 1'b0;
          while (want_q.size() != 0) @(posedge clk);
          @(posedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Parsed %0d characters into %0d checked results in signed and unsigned mode,",
             n_items, n_res);
    $display("including %0d saturated values and %0d sign errors.", n_ovf, n_serr);
    if (n_err == 0)
      $display("decimal_text_to_int64_saturating test passed");
    else
      $display("decimal_text_to_int64_saturating test failed");
    $finish;
  end

endmodule
